// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the drawing unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising i_clk edge outside reset
`define MPFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define MPFB_ASSERT_NEVER(label, cond, msg) \
    `MPFB_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/mpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, command codes and control types of the drawing unit.
// ----------------------------------------------------------------------------
package mpfb_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int PAGE_ROWS        = 8;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 8;
    localparam int BIDX_W  = 10;
    localparam int BYTE_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_PIXEL = 3'd1,
        CMD_LINE  = 3'd2,
        CMD_RECT  = 3'd3,
        CMD_FILL  = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic load;
        logic step;
    } t_line_ctl;

endpackage

// ===== rtl/core/mpfb_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mpfb_cmd_if
// Drawing command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface mpfb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [mpfb_pkg::CMD_W-1:0]          cmd;
    logic [mpfb_pkg::COORD_W-1:0]        xa;
    logic [mpfb_pkg::COORD_W-1:0]        ya;
    logic [mpfb_pkg::COORD_W-1:0]        xb;
    logic [mpfb_pkg::COORD_W-1:0]        yb;
    logic                                ink;
    logic [mpfb_pkg::BIDX_W-1:0]         byte_index;

    modport source (output valid, cmd, xa, ya, xb, yb, ink, byte_index, input ready);
    modport sink   (input valid, cmd, xa, ya, xb, yb, ink, byte_index, output ready);
endinterface

// ===== rtl/core/mpfb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mpfb_rsp_if
// Result channel: valid/ready handshake carrying the read-back byte.
// ----------------------------------------------------------------------------
interface mpfb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mpfb_pkg::BYTE_W-1:0] read_byte;

    modport source (output valid, read_byte, input ready);
    modport sink   (input valid, read_byte, output ready);
endinterface

// ===== rtl/core/mpfb_store.sv =====
// ----------------------------------------------------------------------------
// mpfb_store
// Frame store: single-port byte memory, one address per cycle that is read and,
// when i_we is set, written; registered read data (the byte before the write).
// ----------------------------------------------------------------------------
module mpfb_store #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_addr,
    input  logic [mpfb_pkg::BYTE_W-1:0] i_wdata,
    output logic [mpfb_pkg::BYTE_W-1:0] o_rdata
);

    logic [mpfb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [mpfb_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mpfb_line_unit.sv =====
// ----------------------------------------------------------------------------
// mpfb_line_unit
// Bresenham stepper: loads a segment, then advances one pixel per step.
// ----------------------------------------------------------------------------
module mpfb_line_unit (
    input  logic                         i_clk,
    input  mpfb_pkg::t_line_ctl          i_ctl,
    input  logic [mpfb_pkg::COORD_W-1:0] i_x0,
    input  logic [mpfb_pkg::COORD_W-1:0] i_y0,
    input  logic [mpfb_pkg::COORD_W-1:0] i_x1,
    input  logic [mpfb_pkg::COORD_W-1:0] i_y1,
    output logic [mpfb_pkg::COORD_W-1:0] o_x,
    output logic [mpfb_pkg::COORD_W-1:0] o_y,
    output logic                         o_end
);

    logic [mpfb_pkg::COORD_W-1:0] r_x, r_y, r_x1, r_y1;
    logic signed [11:0]           r_dx, r_dy, r_err;
    logic                         r_sx, r_sy;

    logic signed [11:0] n_dx, n_dy, e2, n_err;
    logic               step_x, step_y;

    always_comb begin
        n_dx   = (i_x1 > i_x0) ? $signed({4'd0, i_x1 - i_x0}) : $signed({4'd0, i_x0 - i_x1});
        n_dy   = (i_y1 > i_y0) ? $signed({4'd0, i_y1 - i_y0}) : $signed({4'd0, i_y0 - i_y1});
        e2     = r_err <<< 1;
        step_x = e2 > -r_dy;
        step_y = e2 < r_dx;
        n_err  = r_err - (step_x ? r_dy : 12'sd0) + (step_y ? r_dx : 12'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_x1  <= i_x1;
            r_y1  <= i_y1;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_sx  <= i_x0 < i_x1;
            r_sy  <= i_y0 < i_y1;
            r_err <= n_dx - n_dy;
        end else if (i_ctl.step) begin
            r_err <= n_err;
            if (step_x) begin
                r_x <= r_sx ? r_x + 8'd1 : r_x - 8'd1;
            end
            if (step_y) begin
                r_y <= r_sy ? r_y + 8'd1 : r_y - 8'd1;
            end
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_end = (r_x == r_x1) && (r_y == r_y1);

endmodule

// ===== rtl/core/mono_page_framebuffer_line_rect_draw_unit.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_line_rect_draw_unit
// Drawing engine for a page-organized 1 bpp frame buffer.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one drawing command per transfer; o_rsp returns exactly one
//   byte per command (the store byte for a read inside the store, zero otherwise).
//   A command is taken only while the sequencer is idle; all store updates run
//   through one read-modify-write port of the frame store.
//   Work per command: a clear writes zero to one byte per cycle; a pixel on
//   the panel reads and writes its byte; a line reads and writes the byte of
//   each panel pixel and steps over off-panel pixels without a write; an
//   outline draws four lines; a filled rect reads and writes each covered
//   page byte.
//   The store port is the limit: each drawn byte costs a read and a write.
//   After reset all STORE_BYTES bytes of the store (1024 for 128x64) are wiped
//   before the first command is taken.
//   A finished result sits in an output register; while the receiver stalls
//   the next command is taken and worked on, and only its result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_page_framebuffer_line_rect_draw_unit #(
    parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpfb_cmd_if.sink       i_cmd,
    mpfb_rsp_if.source     o_rsp
);

    localparam int STORE_BYTES = PANEL_WIDTH *
        ((PANEL_HEIGHT + mpfb_pkg::PAGE_ROWS - 1) / mpfb_pkg::PAGE_ROWS);
    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [8:0]    W_LIM     = 9'(PANEL_WIDTH);
    localparam logic [8:0]    H_LIM     = 9'(PANEL_HEIGHT);
    localparam logic [7:0]    X_MAX     = 8'(PANEL_WIDTH - 1);
    localparam logic [7:0]    Y_MAX     = 8'(PANEL_HEIGHT - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_PRD, S_PWR, S_LLOAD, S_LRD, S_LWR,
        S_FRD, S_FWR, S_RRD, S_RWAIT, S_DONE
    } t_state;

    t_state           r_state;
    mpfb_pkg::t_cmd   r_cmd;
    logic [7:0]       r_xa, r_ya, r_xb, r_yb;
    logic [7:0]       r_lx, r_hx, r_ly, r_hy;
    logic             r_ink;
    logic [9:0]       r_bi;
    logic [1:0]       r_seg;
    logic [7:0]       r_fx;
    logic [4:0]       r_fp;
    logic [AW-1:0]    r_caddr;
    logic [7:0]       r_res;
    logic             r_report;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;

    // accept-side corner ordering and fill clipping
    logic [7:0] c_lx, c_hx, c_ly, c_hy, c_hxc, c_hyc;
    logic       c_fill_empty;

    always_comb begin
        c_lx  = (i_cmd.xa < i_cmd.xb) ? i_cmd.xa : i_cmd.xb;
        c_hx  = (i_cmd.xa < i_cmd.xb) ? i_cmd.xb : i_cmd.xa;
        c_ly  = (i_cmd.ya < i_cmd.yb) ? i_cmd.ya : i_cmd.yb;
        c_hy  = (i_cmd.ya < i_cmd.yb) ? i_cmd.yb : i_cmd.ya;
        c_hxc = (c_hx > X_MAX) ? X_MAX : c_hx;
        c_hyc = (c_hy > Y_MAX) ? Y_MAX : c_hy;
        c_fill_empty = (c_lx > c_hxc) || (c_ly > c_hyc);
    end

    // line unit hookup
    mpfb_pkg::t_line_ctl line_ctl;
    logic [7:0] lx0, ly0, lx1, ly1, line_x, line_y;
    logic       line_end;

    always_comb begin
        if (r_cmd == mpfb_pkg::CMD_LINE) begin
            lx0 = r_xa; ly0 = r_ya; lx1 = r_xb; ly1 = r_yb;
        end else begin
            case (r_seg)
                2'd0:    begin lx0 = r_lx; ly0 = r_ly; lx1 = r_hx; ly1 = r_ly; end
                2'd1:    begin lx0 = r_hx; ly0 = r_ly; lx1 = r_hx; ly1 = r_hy; end
                2'd2:    begin lx0 = r_hx; ly0 = r_hy; lx1 = r_lx; ly1 = r_hy; end
                default: begin lx0 = r_lx; ly0 = r_hy; lx1 = r_lx; ly1 = r_ly; end
            endcase
        end
    end

    mpfb_line_unit u_line (
        .i_clk (i_clk),
        .i_ctl (line_ctl),
        .i_x0  (lx0),
        .i_y0  (ly0),
        .i_x1  (lx1),
        .i_y1  (ly1),
        .o_x   (line_x),
        .o_y   (line_y),
        .o_end (line_end)
    );

    // store port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;

    mpfb_store #(.DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // address, mask and write data
    logic        fill_st, pix_st, pt_in, set_bits, bi_in;
    logic [7:0]  px, py, ax, mask, fmask;
    logic [4:0]  ap;
    logic [2:0]  f_lo, f_hi;
    logic [13:0] addr_full;

    always_comb begin
        fill_st = (r_state == S_FRD) || (r_state == S_FWR);
        pix_st  = (r_state == S_PRD) || (r_state == S_PWR);
        px      = pix_st ? r_xa : line_x;
        py      = pix_st ? r_ya : line_y;
        pt_in   = ({1'b0, px} < W_LIM) && ({1'b0, py} < H_LIM);
        ax      = fill_st ? r_fx : px;
        ap      = fill_st ? r_fp : py[7:3];
        addr_full = 14'(ax) + 14'(ap) * 14'(PANEL_WIDTH);
        bi_in   = {4'd0, r_bi} < 14'(STORE_BYTES);

        f_lo  = (r_fp == r_ly[7:3]) ? r_ly[2:0] : 3'd0;
        f_hi  = (r_fp == r_hy[7:3]) ? r_hy[2:0] : 3'd7;
        fmask = (8'hFF << f_lo) & (8'hFF >> (3'd7 - f_hi));
        mask  = fill_st ? fmask : (8'd1 << py[2:0]);

        set_bits = (r_state == S_PWR) ? r_ink : 1'b1;
        mem_we   = (r_state == S_CLR) || (r_state == S_PWR) ||
                   (r_state == S_LWR) || (r_state == S_FWR);

        unique case (r_state)
            S_CLR:   mem_addr = r_caddr;
            S_RRD:   mem_addr = AW'(r_bi);
            default: mem_addr = AW'(addr_full);
        endcase

        if (r_state == S_CLR) begin
            mem_wdata = 8'd0;
        end else if (set_bits) begin
            mem_wdata = mem_rdata | mask;
        end else begin
            mem_wdata = mem_rdata & ~mask;
        end

        line_ctl.load = (r_state == S_LLOAD);
        line_ctl.step = !line_end &&
                        ((r_state == S_LWR) || ((r_state == S_LRD) && !pt_in));
    end

    logic seg_more;
    assign seg_more = (r_cmd == mpfb_pkg::CMD_RECT) && (r_seg != 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_caddr     <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmd       <= mpfb_pkg::CMD_CLEAR;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd    <= mpfb_pkg::t_cmd'(i_cmd.cmd);
                        r_xa     <= i_cmd.xa;
                        r_ya     <= i_cmd.ya;
                        r_xb     <= i_cmd.xb;
                        r_yb     <= i_cmd.yb;
                        r_ink    <= i_cmd.ink;
                        r_bi     <= i_cmd.byte_index;
                        r_lx     <= c_lx;
                        r_ly     <= c_ly;
                        r_hx     <= c_hx;
                        r_hy     <= c_hy;
                        r_seg    <= 2'd0;
                        r_fx     <= c_lx;
                        r_fp     <= c_ly[7:3];
                        r_caddr  <= '0;
                        r_res    <= 8'd0;
                        r_report <= 1'b1;
                        unique case (mpfb_pkg::t_cmd'(i_cmd.cmd)) inside
                            mpfb_pkg::CMD_CLEAR: r_state <= S_CLR;
                            mpfb_pkg::CMD_PIXEL: r_state <= S_PRD;
                            mpfb_pkg::CMD_LINE,
                            mpfb_pkg::CMD_RECT:  r_state <= S_LLOAD;
                            mpfb_pkg::CMD_FILL: begin
                                r_hx    <= c_hxc;
                                r_hy    <= c_hyc;
                                r_state <= c_fill_empty ? S_DONE : S_FRD;
                            end
                            mpfb_pkg::CMD_READ:  r_state <= S_RRD;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_caddr == LAST_ADDR) begin
                        r_state <= S_DONE;
                    end else begin
                        r_caddr <= r_caddr + AW'(1);
                    end
                end
                S_PRD: r_state <= pt_in ? S_PWR : S_DONE;
                S_PWR: r_state <= S_DONE;
                S_LLOAD: r_state <= S_LRD;
                S_LRD: begin
                    if (pt_in) begin
                        r_state <= S_LWR;
                    end else if (line_end) begin
                        if (seg_more) begin
                            r_seg   <= r_seg + 2'd1;
                            r_state <= S_LLOAD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LWR: begin
                    if (!line_end) begin
                        r_state <= S_LRD;
                    end else if (seg_more) begin
                        r_seg   <= r_seg + 2'd1;
                        r_state <= S_LLOAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FRD: r_state <= S_FWR;
                S_FWR: begin
                    if (r_fx == r_hx) begin
                        r_fx <= r_lx;
                        if (r_fp == r_hy[7:3]) begin
                            r_state <= S_DONE;
                        end else begin
                            r_fp    <= r_fp + 5'd1;
                            r_state <= S_FRD;
                        end
                    end else begin
                        r_fx    <= r_fx + 8'd1;
                        r_state <= S_FRD;
                    end
                end
                S_RRD: r_state <= bi_in ? S_RWAIT : S_DONE;
                S_RWAIT: begin
                    r_res   <= mem_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= r_report;
                        r_out_byte  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_byte = r_out_byte;

    `MPFB_ASSERT(a_busy_after_transfer, (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready, "command taken while busy")
    `MPFB_ASSERT(a_result_from_done, $rose(o_rsp.valid) |-> $past(r_state == S_DONE), "result raised outside done")
    `MPFB_ASSERT(a_line_write_on_panel, (r_state == S_LWR) |-> pt_in, "line write off the panel")
    `MPFB_ASSERT_NEVER(a_fill_past_edge, (r_state == S_FWR) && (r_fx > r_hx), "fill ran past right edge")

endmodule
